// ----- rtl/core/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the PLL divider search pipeline.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned TargetW = 31;
  localparam int unsigned RefW    = 26;
  localparam int unsigned FbW     = 9;
  localparam int unsigned PdW     = 3;
  localparam int unsigned RdW     = 6;
  localparam int unsigned ProdW   = 12;
  localparam int unsigned NumW    = TargetW + ProdW;   // target * prod + ref / 2
  localparam int unsigned ActW    = RefW + FbW;        // ref * fb
  localparam int unsigned HzW     = 34;

  localparam logic [RdW-1:0]   RdMax  = 6'd63;
  localparam logic [PdW-1:0]   PdMax  = 3'd7;
  localparam logic [FbW-1:0]   FbMin  = 9'd16;
  localparam logic [FbW-1:0]   FbMax  = 9'd320;
  localparam logic [ActW-1:0]  ErrStart = 35'h0_FFFF_FFFF;
  localparam logic [HzW-1:0]   HzSat  = 34'h3_FFFF_FFFF;
  localparam logic [RefW-1:0]  RefReset = 26'd12000000;

  // drain wait after the last issue, longer than the whole pipeline
  localparam int unsigned DrainW = 6;

  typedef struct packed {
    logic             vld;
    logic [RdW-1:0]   rd;
    logic [PdW-1:0]   p1;
    logic [PdW-1:0]   p2;
    logic [ProdW-1:0] prod;
  } cmb_t;

endpackage

// ----- rtl/core/pll_divider_search.sv -----
// ----------------------------------------------------------------------------
// pll_divider_search
// Searches reference and post dividers for the feedback divider setting
// that best approaches a requested output frequency.
// ----------------------------------------------------------------------------
// Usage:
//   input item  : target_hz_i with in_valid_i, held while in_stall_o is high
//   result item : dividers and achieved_hz_o with out_valid_o, held while
//                 out_stall_i is high
//   config      : ref_clock_hz_i written with cfg_valid_i, cfg_ready_o is
//                 always high; write only while no search is running
// One combination of ref_div, post_div_one, post_div_two enters the divider
// pipeline per cycle, up to 3087 in nested order; an exact match stops the
// issue once the matching combination reaches the best-so-far register. After
// the last issue the block waits on its drain counter for the pipeline (the
// multipliers and two bit-per-stage dividers) to empty; a zero reference
// clock skips the issue and goes straight to that drain wait.
// One search runs at a time; the next item is accepted as soon as the
// result is in the output register, even if the receiver stalls it.
// A finished result waits in the search unit while the output is still full.
// Reset leaves the block idle with ref_clock_hz at 12 MHz.
// ----------------------------------------------------------------------------
module pll_divider_search import pds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TargetW-1:0] target_hz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FbW-1:0]     feedback_div_o,
  output logic [PdW-1:0]     post_div_one_o,
  output logic [PdW-1:0]     post_div_two_o,
  output logic [RdW-1:0]     ref_div_o,
  output logic [HzW-1:0]     achieved_hz_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RefW-1:0]    ref_clock_hz_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRun   = 4'b0010,
    StDrain = 4'b0100,
    StHold  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [RefW-1:0]    ref_q;
  logic [TargetW-1:0] target_q;
  logic [RdW-1:0]     rd_q;
  logic [PdW-1:0]     p1_q, p2_q;
  logic [DrainW-1:0]  drain_q;
  logic               exact_q;

  logic               last_combo, finish, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign last_combo  = (rd_q == RdMax) && (p1_q == PdMax) && (p2_q == PdMax);
  assign out_free    = !out_valid_o || !out_stall_i;
  assign finish      = ((state_q == StDrain) && (drain_q == '1)) || (state_q == StHold);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = (ref_q == '0) ? StDrain : StRun;
      end
      StRun: begin
        if (last_combo || exact_q) state_d = StDrain;
      end
      StDrain: begin
        if (drain_q == '1) state_d = out_free ? StIdle : StHold;
      end
      StHold: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ref_q   <= RefReset;
      rd_q    <= 6'd1;
      p1_q    <= 3'd1;
      p2_q    <= 3'd1;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) ref_q <= ref_clock_hz_i;
      if (state_q == StIdle) begin
        rd_q    <= 6'd1;
        p1_q    <= 3'd1;
        p2_q    <= 3'd1;
        drain_q <= '0;
      end else if (state_q == StRun) begin
        if (p2_q == PdMax) begin
          p2_q <= 3'd1;
          if (p1_q == PdMax) begin
            p1_q <= 3'd1;
            rd_q <= rd_q + 6'd1;
          end else begin
            p1_q <= p1_q + 3'd1;
          end
        end else begin
          p2_q <= p2_q + 3'd1;
        end
      end else if (state_q == StDrain) begin
        drain_q <= drain_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) target_q <= target_hz_i;
  end

  // issue stages: p1 * p2, then times rd
  cmb_t            cmb_a_q, cmb_b_q;
  logic [5:0]      p12_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmb_a_q <= '0;
      cmb_b_q <= '0;
    end else begin
      cmb_a_q.vld  <= (state_q == StRun) && !exact_q;
      cmb_a_q.rd   <= rd_q;
      cmb_a_q.p1   <= p1_q;
      cmb_a_q.p2   <= p2_q;
      cmb_a_q.prod <= '0;
      cmb_b_q      <= '{vld: cmb_a_q.vld, rd: cmb_a_q.rd, p1: cmb_a_q.p1,
                        p2: cmb_a_q.p2,
                        prod: ProdW'(cmb_a_q.rd) * ProdW'(p12_a_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    p12_a_q <= 6'(p1_q) * 6'(p2_q);
  end

  cmb_t           cmb_f, cmb_g;
  logic [FbW-1:0] fb_f, fb_g;
  logic           fit_f;
  logic [ActW-1:0] act_g;

  pds_fb_div u_fb_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmb_i    (cmb_b_q),
    .target_i (target_q),
    .ref_i    (ref_q),
    .cmb_o    (cmb_f),
    .fb_o     (fb_f),
    .fit_o    (fit_f)
  );

  pds_act_div u_act_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmb_i  (cmb_f),
    .fb_i   (fb_f),
    .fit_i  (fit_f),
    .ref_i  (ref_q),
    .cmb_o  (cmb_g),
    .fb_o   (fb_g),
    .act_o  (act_g)
  );

  // error stage
  cmb_t            cmb_e_q;
  logic [FbW-1:0]  fb_e_q;
  logic [ActW-1:0] act_e_q, err_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmb_e_q <= '0;
    end else begin
      cmb_e_q <= cmb_g;
    end
  end

  always_ff @(posedge clk_i) begin
    fb_e_q  <= fb_g;
    act_e_q <= act_g;
    err_e_q <= (act_g > ActW'(target_q)) ? act_g - ActW'(target_q)
                                          : ActW'(target_q) - act_g;
  end

  // best so far; in-order arrival keeps the first of equal errors
  logic [ActW-1:0] best_err_q;
  logic [FbW-1:0]  best_fb_q;
  logic [PdW-1:0]  best_p1_q, best_p2_q;
  logic [RdW-1:0]  best_rd_q;
  logic [ActW-1:0] best_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_err_q <= ErrStart;
      best_fb_q  <= '0;
      best_p1_q  <= '0;
      best_p2_q  <= '0;
      best_rd_q  <= '0;
      best_act_q <= '0;
      exact_q    <= 1'b0;
    end else if (state_q == StIdle) begin
      best_err_q <= ErrStart;
      best_fb_q  <= '0;
      best_p1_q  <= '0;
      best_p2_q  <= '0;
      best_rd_q  <= '0;
      best_act_q <= '0;
      exact_q    <= 1'b0;
    end else if (cmb_e_q.vld && (err_e_q < best_err_q)) begin
      best_err_q <= err_e_q;
      best_fb_q  <= fb_e_q;
      best_p1_q  <= cmb_e_q.p1;
      best_p2_q  <= cmb_e_q.p2;
      best_rd_q  <= cmb_e_q.rd;
      best_act_q <= act_e_q;
      if (err_e_q == '0) exact_q <= 1'b1;
    end
  end

  // output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish && out_free) begin
      feedback_div_o <= best_fb_q;
      post_div_one_o <= best_p1_q;
      post_div_two_o <= best_p2_q;
      ref_div_o      <= best_rd_q;
      achieved_hz_o  <= best_act_q[ActW-1] ? HzSat : best_act_q[HzW-1:0];
    end
  end

endmodule

// ----- rtl/core/pds_fb_div.sv -----
// ----------------------------------------------------------------------------
// pds_fb_div
// Rounded feedback divider: (target * prod + ref / 2) / ref, one quotient
// bit per stage, with a range check against the legal feedback window.
// ----------------------------------------------------------------------------
module pds_fb_div import pds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmb_t               cmb_i,
  input  logic [TargetW-1:0] target_i,
  input  logic [RefW-1:0]    ref_i,
  output cmb_t               cmb_o,
  output logic [FbW-1:0]     fb_o,
  output logic               fit_o
);

  cmb_t            cmb_c_q, cmb_d_q;
  logic [NumW-1:0] num_c_q, num_d_q;

  cmb_t            cmb_q [0:FbW];
  logic            ovf_q [0:FbW];
  logic [NumW-1:0] rem_q [0:FbW];
  logic [FbW-1:0]  quo_q [0:FbW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmb_c_q <= '0;
      cmb_d_q <= '0;
      cmb_q[0] <= '0;
    end else begin
      cmb_c_q <= cmb_i;
      cmb_d_q <= cmb_c_q;
      cmb_q[0] <= cmb_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_c_q  <= NumW'(target_i) * NumW'(cmb_i.prod);
    num_d_q  <= num_c_q + NumW'(ref_i >> 1);
    // quotient of 512 or more is out of range anyway
    ovf_q[0] <= num_d_q >= {8'd0, ref_i, 9'd0};
    rem_q[0] <= num_d_q;
    quo_q[0] <= '0;
  end

  for (genvar i = 0; i < FbW; i++) begin : g_stage
    logic [NumW-1:0] dsh;
    logic            ge;
    assign dsh = NumW'(ref_i) << (FbW - 1 - i);
    assign ge  = rem_q[i] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cmb_q[i+1] <= '0;
      end else begin
        cmb_q[i+1] <= cmb_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[i+1] <= ovf_q[i];
      rem_q[i+1] <= ge ? rem_q[i] - dsh : rem_q[i];
      quo_q[i+1] <= {quo_q[i][FbW-2:0], ge};
    end
  end

  assign cmb_o = cmb_q[FbW];
  assign fb_o  = quo_q[FbW];
  assign fit_o = cmb_q[FbW].vld && !ovf_q[FbW] &&
                 (quo_q[FbW] >= FbMin) && (quo_q[FbW] <= FbMax);

endmodule

// ----- rtl/core/pds_act_div.sv -----
// ----------------------------------------------------------------------------
// pds_act_div
// Achieved frequency: ref * fb / prod, truncated, restoring divider with
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module pds_act_div import pds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmb_t            cmb_i,
  input  logic [FbW-1:0]  fb_i,
  input  logic            fit_i,
  input  logic [RefW-1:0] ref_i,
  output cmb_t            cmb_o,
  output logic [FbW-1:0]  fb_o,
  output logic [ActW-1:0] act_o
);

  localparam int unsigned DshW = ActW + ProdW;

  cmb_t            cmb_q [0:ActW];
  logic [FbW-1:0]  fb_q  [0:ActW];
  logic [ActW-1:0] rem_q [0:ActW];
  logic [ActW-1:0] quo_q [0:ActW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmb_q[0] <= '0;
    end else begin
      cmb_q[0] <= '{vld: fit_i, rd: cmb_i.rd, p1: cmb_i.p1, p2: cmb_i.p2,
                    prod: cmb_i.prod};
    end
  end

  always_ff @(posedge clk_i) begin
    fb_q[0]  <= fb_i;
    rem_q[0] <= ActW'(ref_i) * ActW'(fb_i);
    quo_q[0] <= '0;
  end

  for (genvar i = 0; i < ActW; i++) begin : g_stage
    logic [DshW-1:0] dsh;
    logic            ge;
    assign dsh = DshW'(cmb_q[i].prod) << (ActW - 1 - i);
    assign ge  = DshW'(rem_q[i]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cmb_q[i+1] <= '0;
      end else begin
        cmb_q[i+1] <= cmb_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      fb_q[i+1]  <= fb_q[i];
      rem_q[i+1] <= ge ? rem_q[i] - dsh[ActW-1:0] : rem_q[i];
      quo_q[i+1] <= {quo_q[i][ActW-2:0], ge};
    end
  end

  assign cmb_o = cmb_q[ActW];
  assign fb_o  = fb_q[ActW];
  assign act_o = quo_q[ActW];

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pll_divider_search: drives target frequencies
// under random valid/stall gaps across several reference clock settings and
// compares every result against an exhaustive divider search done in the bench.
// ----------------------------------------------------------------------------
module tb import pds_pkg::*; ();

  typedef struct {
    logic [FbW-1:0]  fb;
    logic [PdW-1:0]  p1;
    logic [PdW-1:0]  p2;
    logic [RdW-1:0]  rd;
    logic [HzW-1:0]  hz;
  } pll_set_t;

  localparam int unsigned RdTop = 63;
  localparam int unsigned PdTop = 7;
  localparam int unsigned FbLo  = 16;
  localparam int unsigned FbHi  = 320;

  // exhaustive search in nested order, first best wins, exact match stops
  function automatic pll_set_t search_dividers(logic [TargetW-1:0] tgt,
                                               logic [RefW-1:0] refclk);
    pll_set_t best;
    longint unsigned t, r, prod, fb, act, err, best_err, best_hz;
    bit hit;
    t = tgt;
    r = refclk;
    best_err = 64'hFFFF_FFFF;
    best_hz = 0;
    hit = 0;
    best = '{default: '0};
    if (r != 0) begin
      for (int rd = 1; rd <= RdTop && !hit; rd++)
        for (int p1 = 1; p1 <= PdTop && !hit; p1++)
          for (int p2 = 1; p2 <= PdTop && !hit; p2++) begin
            prod = rd * p1 * p2;
            fb = (t * prod + r / 2) / r;
            if (fb >= FbLo && fb <= FbHi) begin
              act = (r * fb) / prod;
              err = (act > t) ? act - t : t - act;
              if (err < best_err) begin
                best_err = err;
                best.fb = fb[FbW-1:0];
                best.p1 = p1[PdW-1:0];
                best.p2 = p2[PdW-1:0];
                best.rd = rd[RdW-1:0];
                best_hz = act;
                if (err == 0) hit = 1;
              end
            end
          end
    end
    best.hz = (best_hz > 64'h3_FFFF_FFFF) ? HzSat : best_hz[HzW-1:0];
    return best;
  endfunction

  class pll_scoreboard;
    pll_set_t expected_q[$];
    int errors;

    function void note_target(logic [TargetW-1:0] tgt, logic [RefW-1:0] refclk);
      expected_q.push_back(search_dividers(tgt, refclk));
    endfunction

    function void check_result(pll_set_t got);
      pll_set_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.fb !== exp.fb) begin
        $error("feedback_div exp %0d got %0d", exp.fb, got.fb); errors++;
      end
      if (got.p1 !== exp.p1) begin
        $error("post_div_one exp %0d got %0d", exp.p1, got.p1); errors++;
      end
      if (got.p2 !== exp.p2) begin
        $error("post_div_two exp %0d got %0d", exp.p2, got.p2); errors++;
      end
      if (got.rd !== exp.rd) begin
        $error("ref_div exp %0d got %0d", exp.rd, got.rd); errors++;
      end
      if (got.hz !== exp.hz) begin
        $error("achieved_hz exp %0d got %0d", exp.hz, got.hz); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [TargetW-1:0] target_hz_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [FbW-1:0]     feedback_div_o;
  logic [PdW-1:0]     post_div_one_o;
  logic [PdW-1:0]     post_div_two_o;
  logic [RdW-1:0]     ref_div_o;
  logic [HzW-1:0]     achieved_hz_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [RefW-1:0]    ref_clock_hz_i = '0;

  pll_scoreboard sb = new();
  logic [RefW-1:0] cur_ref = RefReset;
  bit calm = 0;
  bit hold_go = 0;
  int hold_left = 0;

  always #1 clk_i = ~clk_i;

  pll_divider_search dut (.*);

  // result side: check accepted items, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{feedback_div_o, post_div_one_o, post_div_two_o,
                          ref_div_o, achieved_hz_o});
      if (hold_go) begin
        hold_go = 0;
        hold_left = 10000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  task automatic send_target(logic [TargetW-1:0] tgt);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_hz_i <= tgt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_target(tgt, cur_ref);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_ref(logic [RefW-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    ref_clock_hz_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_ref = v;
  endtask

  function automatic logic [TargetW-1:0] rand_target();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return TargetW'($urandom_range(2000000000, 1000000));
    if (pick < 85) return TargetW'($urandom() & 32'h7FFF_FFFF);
    return TargetW'($urandom_range(5000000, 0));
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_target(rand_target());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed at the reset reference clock
    send_target('0);
    send_target(31'd1);
    send_target(31'h7FFF_FFFF);
    send_target(31'd2000000000);
    send_target(31'd125000000);
    send_target(31'd48000000);
    send_target(31'd12000000);
    send_target(31'd1000);
    send_target(31'd100000000);
    send_target(31'd133333333);
    send_target(31'h5555_5555);
    send_target(31'h2AAA_AAAA);
    send_target(31'd1500000000);
    send_target(31'd24000000);
    // fill up behind a long receiver hold-off
    hold_go = 1;
    random_burst(50);

    write_ref(26'd1000000);
    random_burst(30);

    write_ref(26'd50000000);
    calm = 1;
    random_burst(40);
    calm = 0;

    // top of the register, with the largest target
    write_ref(26'h3FF_FFFF);
    send_target(31'h7FFF_FFFF);
    random_burst(14);

    // zero reference clock gives all-zero results
    write_ref('0);
    random_burst(5);

    write_ref(RefW'($urandom_range(50000000, 1000000)));
    random_burst(40);

    in_valid_i <= 1'b0;
    for (int i = 0; i < 20000 && sb.expected_q.size() != 0; i++) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    sb.errors += sb.expected_q.size();
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #8000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
